// ===== rtl/f2i_pkg.sv =====
`timescale 1ns / 1ps
package f2i_pkg;

  typedef enum logic [2:0] {
    RM_RNE = 3'd0,
    RM_RTZ = 3'd1,
    RM_RDN = 3'd2,
    RM_RUP = 3'd3,
    RM_RMM = 3'd4
  } round_mode_e;

  localparam logic [63:0] Mask32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] Smax32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] Smax64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Smin32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] Smin64 = 64'h8000_0000_0000_0000;

  // unpacked operand handed from the decode stage to the round stage
  typedef struct packed {
    logic        special;   // NaN or infinity
    logic        zero;
    logic        neg;
    logic [52:0] sig;
    logic [12:0] exp2;      // signed unbiased exponent of sig lsb
    logic        uns;
    logic        w64;
    logic [2:0]  rm;
  } unpacked_t;

  function automatic logic [63:0] saturate(input logic neg, input logic uns,
                                           input logic w64);
    logic [63:0] r;
    if (uns) r = neg ? 64'd0 : (w64 ? '1 : Mask32);
    else     r = neg ? (w64 ? Smin64 : Smin32) : (w64 ? Smax64 : Smax32);
    return r;
  endfunction

endpackage

// ===== rtl/f2i_unpack.sv =====
`timescale 1ns / 1ps
module f2i_unpack (
  input  logic               source_is_double_i,
  input  logic [63:0]        float_bits_i,
  input  logic               unsigned_target_i,
  input  logic               target_is_64_i,
  input  logic [2:0]         round_mode_i,
  output f2i_pkg::unpacked_t unp_o
);
  import f2i_pkg::*;

  logic [10:0] ef;
  logic [51:0] frac;
  logic        is_max;

  always_comb begin
    if (source_is_double_i) begin
      ef     = float_bits_i[62:52];
      frac   = float_bits_i[51:0];
      is_max = &float_bits_i[62:52];
      unp_o.neg  = float_bits_i[63];
      unp_o.sig  = {(ef != '0), frac};
      unp_o.exp2 = 13'(ef == '0 ? 11'd1 : ef) - 13'd1075;
    end else begin
      ef     = {3'b000, float_bits_i[30:23]};
      frac   = {29'd0, float_bits_i[22:0]};
      is_max = &float_bits_i[30:23];
      unp_o.neg  = float_bits_i[31];
      unp_o.sig  = {29'd0, (ef != '0), frac[22:0]};
      unp_o.exp2 = 13'(ef == '0 ? 11'd1 : ef) - 13'd150;
    end
    unp_o.special = is_max;
    // NaN takes the positive limit
    if (is_max && frac != '0) unp_o.neg = 1'b0;
    unp_o.zero = (unp_o.sig == '0);
    unp_o.uns  = unsigned_target_i;
    unp_o.w64  = target_is_64_i;
    unp_o.rm   = round_mode_i;
  end
endmodule

// ===== rtl/f2i_round.sv =====
`timescale 1ns / 1ps
module f2i_round (
  input  f2i_pkg::unpacked_t unp_i,
  output logic [63:0]        integer_bits_o,
  output logic               nv_flag_o,
  output logic               inexact_flag_o
);
  import f2i_pkg::*;

  logic [63:0]  mag;
  logic [64:0]  mag_r;
  logic [52:0]  rem;
  logic         half_bit, low_sticky, up, ovf, big;
  logic [6:0]   rs;
  logic [5:0]   ls;
  logic [63:0]  lim_mask, lim_smin, lim_smax;

  always_comb begin
    ls = '0; rs = '0;
    big = 1'b0;
    rem = '0;
    mag = '0;
    up  = 1'b0;
    half_bit = 1'b0; low_sticky = 1'b0;
    if (!unp_i.exp2[12]) begin
      // left shift: overflow when exponent too large
      ls  = unp_i.exp2[5:0];
      big = (unp_i.exp2 >= 13'd64) ||
            ((({64'd0, unp_i.sig[52:0]} << ls) >> 64) != '0);
      mag = 64'(unp_i.sig) << ls;
    end else begin
      if ($signed(unp_i.exp2) < -13'sd60) begin
        rem = 53'd1;
        low_sticky = 1'b1;
      end else begin
        rs  = 7'(-unp_i.exp2);
        mag = 64'(unp_i.sig >> rs);
        rem = unp_i.sig & ((53'd1 << rs) - 53'd1);
        // half weight lies above the significand for very small values
        half_bit = (rs <= 7'd53) && unp_i.sig[6'(rs - 7'd1)];
        low_sticky = (unp_i.sig & ((53'd1 << (rs - 7'd1)) - 53'd1)) != '0;
      end
      if (rem != '0) begin
        unique case (unp_i.rm)
          RM_RNE:  up = half_bit && (low_sticky || mag[0]);
          RM_RDN:  up = unp_i.neg;
          RM_RUP:  up = !unp_i.neg;
          RM_RMM:  up = half_bit;
          default: up = 1'b0;
        endcase
      end
    end
    mag_r    = {1'b0, mag} + 65'(up);
    lim_mask = unp_i.w64 ? '1 : Mask32;
    lim_smin = unp_i.w64 ? Smin64 : Smin32;
    lim_smax = unp_i.w64 ? Smax64 : Smax32;
    if (unp_i.uns)
      ovf = (unp_i.neg && mag_r != '0) || mag_r > {1'b0, lim_mask};
    else
      ovf = unp_i.neg ? (mag_r > {1'b0, lim_smin}) : (mag_r > {1'b0, lim_smax});
    inexact_flag_o = 1'b0;
    nv_flag_o      = 1'b0;
    if (unp_i.special || big || (!unp_i.zero && ovf)) begin
      integer_bits_o = saturate(unp_i.neg, unp_i.uns, unp_i.w64);
      nv_flag_o      = 1'b1;
    end else if (unp_i.zero) begin
      integer_bits_o = '0;
    end else begin
      integer_bits_o = (unp_i.neg ? (~mag_r[63:0] + 64'd1) : mag_r[63:0]) & lim_mask;
      inexact_flag_o = (rem != '0);
    end
  end
endmodule

// ===== rtl/float_to_integer_converter.sv =====
`timescale 1ns / 1ps
// channel | signals                                  | direction
// in      | in_valid_i/in_ready_o + 5 operand fields | into block
// out     | out_valid_o/out_ready_i + result, flags  | out of block
//
// One item per cycle when not stalled: unpack logic, operand register, then
// round logic, then result register. Result valid once the item enters it.
// Reset clears the valid bits of both stages only.
// A stalled result holds; the operand stage still drains into the result
// register when it is empty, so one item waits in each stage.
module float_to_integer_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        source_is_double_i,
  input  logic [63:0] float_bits_i,
  input  logic        unsigned_target_i,
  input  logic        target_is_64_i,
  input  logic [2:0]  round_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] integer_bits_o,
  output logic        nv_flag_o,
  output logic        inexact_flag_o
);
  import f2i_pkg::*;

  unpacked_t   unp_d, unp_q;
  logic        s1_valid_q, s2_valid_q;
  logic        s1_ready, s2_ready;
  logic [63:0] int_d, int_q;
  logic        inv_d, inv_q, inx_d, inx_q;

  // decode straight from the ports into the operand register
  f2i_unpack u_unpack (
    .source_is_double_i(source_is_double_i),
    .float_bits_i      (float_bits_i),
    .unsigned_target_i (unsigned_target_i),
    .target_is_64_i    (target_is_64_i),
    .round_mode_i      (round_mode_i),
    .unp_o             (unp_d)
  );

  f2i_round u_round (
    .unp_i         (unp_q),
    .integer_bits_o(int_d),
    .nv_flag_o     (inv_d),
    .inexact_flag_o(inx_d)
  );

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) unp_q <= unp_d;
    if (s2_ready && s1_valid_q) begin
      int_q <= int_d;
      inv_q <= inv_d;
      inx_q <= inx_d;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign integer_bits_o = int_q;
  assign nv_flag_o      = inv_q;
  assign inexact_flag_o = inx_q;

  // a stalled result must not move
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(integer_bits_o))
    else $error("result changed under stall");
  // the two flags never come together
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(nv_flag_o && inexact_flag_o))
    else $error("invalid and inexact both set");
  // an accepted item reaches the result register
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> out_valid_o)
    else $error("item lost between stages");
endmodule

// ===== test/float_to_integer_converter_test.sv =====
`timescale 1ns / 1ps
module float_to_integer_converter_test;
  import f2i_pkg::*;

  // Expected conversion result for one item
  typedef struct {
    logic [63:0] value;
    logic        invalid;
    logic        inexact;
  } conversion_t;

  // Keeps the conversions still owed by the block, oldest first
  class conversion_board;
    conversion_t pending[$];
    int          errors;

    function logic [63:0] limit(input logic neg, input logic uns, input logic w64);
      logic [63:0] r;
      if (uns) r = neg ? 64'd0 : (w64 ? 64'hFFFF_FFFF_FFFF_FFFF : Mask32);
      else     r = neg ? (w64 ? Smin64 : Smin32) : (w64 ? Smax64 : Smax32);
      return r;
    endfunction

    // Works out the conversion of one accepted operand
    function void note_operand(input logic dbl, input logic [63:0] bits,
                               input logic uns, input logic w64,
                               input logic [2:0] rm);
      conversion_t c;
      logic        neg, up, exp_all_ones;
      logic [10:0] ef;
      logic [63:0] frac, sig, mag, rem, half;
      int          e2, rs;
      c.invalid = 1'b0;
      c.inexact = 1'b0;
      up = 1'b0;
      if (dbl) begin
        neg  = bits[63];
        ef   = bits[62:52];
        frac = {12'd0, bits[51:0]};
        exp_all_ones = (ef == 11'h7FF);
        sig  = (ef == 0) ? frac : (frac | (64'd1 << 52));
        e2   = ((ef == 0) ? 1 : int'(ef)) - 1075;
      end else begin
        neg  = bits[31];
        ef   = {3'd0, bits[30:23]};
        frac = {41'd0, bits[22:0]};
        exp_all_ones = (ef == 11'h0FF);
        sig  = (ef == 0) ? frac : (frac | (64'd1 << 23));
        e2   = ((ef == 0) ? 1 : int'(ef)) - 150;
      end
      if (exp_all_ones) begin
        // NaN saturates positive whatever its sign
        c.value = limit((frac != 0) ? 1'b0 : neg, uns, w64);
        c.invalid = 1'b1;
      end else if (sig == 0) begin
        c.value = 64'd0;
      end else begin
        if (e2 >= 0) begin
          if (e2 >= 64 || (e2 > 0 && (sig >> (64 - e2)) != 0)) begin
            c.invalid = 1'b1;
            mag = 64'd0;
          end else begin
            mag = sig << e2;
          end
        end else begin
          rs = -e2;
          if (rs > 60) begin
            mag = 0; rem = 1; half = 2;
          end else begin
            mag  = sig >> rs;
            rem  = sig & ((64'd1 << rs) - 1);
            half = 64'd1 << (rs - 1);
          end
          if (rem != 0) begin
            c.inexact = 1'b1;
            case (rm)
              RM_RNE:  up = (rem > half) || (rem == half && mag[0]);
              RM_RDN:  up = neg;
              RM_RUP:  up = !neg;
              RM_RMM:  up = (rem >= half);
              default: up = 1'b0; // unused modes truncate
            endcase
          end
          if (up) mag = mag + 1;
        end
        if (!c.invalid) begin
          if (uns) c.invalid = (neg && mag != 0) || (mag > limit(1'b0, 1'b1, w64));
          else c.invalid = neg ? (mag > limit(1'b1, 1'b0, w64))
                               : (mag > limit(1'b0, 1'b0, w64));
        end
        if (c.invalid) begin
          c.value = limit(neg, uns, w64);
          c.inexact = 1'b0;
        end else begin
          c.value = (neg && !uns) ? ((~mag + 64'd1) & limit(1'b0, 1'b1, w64)) : mag;
        end
      end
      pending.push_back(c);
    endfunction

    function void check_result(input logic [63:0] value, input logic invalid,
                               input logic inexact);
      conversion_t c;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", value);
        errors++;
        return;
      end
      c = pending.pop_front();
      if (value !== c.value) begin
        $error("integer_bits expected %h actual %h", c.value, value);
        errors++;
      end
      if (invalid !== c.invalid) begin
        $error("nv_flag expected %b actual %b", c.invalid, invalid);
        errors++;
      end
      if (inexact !== c.inexact) begin
        $error("inexact_flag expected %b actual %b", c.inexact, inexact);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic        source_is_double_i, unsigned_target_i, target_is_64_i;
  logic [63:0] float_bits_i;
  logic [2:0]  round_mode_i;
  logic        out_valid_o, out_ready_i;
  logic [63:0] integer_bits_o;
  logic        nv_flag_o, inexact_flag_o;

  float_to_integer_converter DUT (.*);

  conversion_board board = new();

  // Idle rates in percent; the receiver may also be held off entirely
  int  send_idle_pct, recv_idle_pct;
  bit  recv_hold;
  int  quiet_cycles;
  bit  timed_out;

  localparam int QuietLimit = 20000;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random ready, checked on each handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i)
        board.check_result(integer_bits_o, nv_flag_o, inexact_flag_o);
      out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one item, with random idle before it, and waits for acceptance
  task automatic send_operand(input logic dbl, input logic [63:0] bits,
                              input logic uns, input logic w64,
                              input logic [2:0] rm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    source_is_double_i <= dbl;
    float_bits_i       <= bits;
    unsigned_target_i  <= uns;
    target_is_64_i     <= w64;
    round_mode_i       <= rm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_operand(dbl, bits, uns, w64, rm);
  endtask

  // Directed sweep of one pattern over every target and a rounding mode
  task automatic send_all_targets(input logic dbl, input logic [63:0] bits,
                                  input logic [2:0] rm);
    for (int t = 0; t < 4; t++) send_operand(dbl, bits, t[0], t[1], rm);
  endtask

  // Random operand biased towards exponents near the integer range
  task automatic send_random;
    logic [63:0] bits;
    logic        dbl;
    int          pick;
    bits = {$urandom, $urandom};
    dbl  = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick < 6) begin
      // exponent around 2^-3 .. 2^67 where rounding and overflow happen
      if (dbl) bits[62:52] = 11'(11'd1020 + $urandom_range(70));
      else     bits[30:23] = 8'(8'd124 + $urandom_range(70));
      if ($urandom_range(3) == 0) begin
        // low fraction bits cleared: exact values and ties
        if (dbl) bits[40:0] = $urandom_range(1) ? 41'd0 : 41'h100_0000_0000;
        else     bits[12:0] = 13'd0;
      end
    end else if (pick == 6) begin
      if (dbl) bits[62:52] = $urandom_range(1) ? 11'h7FF : 11'd0;
      else     bits[30:23] = $urandom_range(1) ? 8'hFF : 8'd0;
    end
    send_operand(dbl, bits, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 3'($urandom_range(7)));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    in_valid_i         = 1'b0;
    source_is_double_i = 1'b0;
    float_bits_i       = '0;
    unsigned_target_i  = 1'b0;
    target_is_64_i     = 1'b0;
    round_mode_i       = RM_RNE;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    recv_hold          = 1'b0;
    rst_ni             = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros, NaN, infinities, ties, subnormal, overflow edges
    send_all_targets(1'b1, 64'h8000_0000_0000_0000, RM_RNE);  // -0
    send_all_targets(1'b1, 64'hFFF8_0000_0000_0001, RM_RNE);  // negative NaN
    send_all_targets(1'b1, 64'hFFF0_0000_0000_0000, RM_RNE);  // -inf
    send_operand(1'b0, 64'hFFFF_FFFF_7F80_0000, 1'b0, 1'b1, RM_RTZ); // +inf, junk top
    send_operand(1'b1, 64'h4004_0000_0000_0000, 1'b0, 1'b0, RM_RNE); // 2.5
    send_operand(1'b1, 64'h4004_0000_0000_0000, 1'b0, 1'b0, RM_RMM);
    send_operand(1'b1, 64'hC004_0000_0000_0000, 1'b0, 1'b0, RM_RDN); // -2.5
    send_operand(1'b1, 64'hC004_0000_0000_0000, 1'b0, 1'b1, RM_RUP);
    send_operand(1'b1, 64'hBFE0_0000_0000_0000, 1'b1, 1'b0, RM_RTZ); // -0.5 unsigned
    send_operand(1'b1, 64'hBFE0_0000_0000_0000, 1'b1, 1'b0, RM_RMM);
    send_operand(1'b1, 64'h0000_0000_0000_0001, 1'b0, 1'b1, RM_RUP); // tiny subnormal
    send_operand(1'b0, 64'h0000_0000_8000_0001, 1'b0, 1'b0, RM_RDN);
    send_operand(1'b1, 64'hC3E0_0000_0000_0000, 1'b0, 1'b1, RM_RNE); // -2^63
    send_operand(1'b1, 64'h43E0_0000_0000_0000, 1'b1, 1'b1, RM_RNE); // 2^63
    send_operand(1'b1, 64'h41DF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 3'd7);   // unused mode
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < 280; n++) begin
        // long receiver hold-off once per phase so the pipe fills and stalls
        if (n == 100) begin
          fork
            begin
              recv_hold = 1'b1;
              repeat (60) @(posedge clk_i);
              recv_hold = 1'b0;
            end
          join_none
        end
        send_random();
      end
    end
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
